// ===== rtl/rc_pulse_width_capture_assert.svh =====
// Assertion macros for the checker of the RC pulse-width capture block.
// Expects signals named clk and arst_n in the scope where a macro is used.
`ifndef RC_PULSE_WIDTH_CAPTURE_ASSERT_SVH
`define RC_PULSE_WIDTH_CAPTURE_ASSERT_SVH

// Plain property, checked out of reset.
`define RCPWC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication with an antecedent and a consequent sequence.
`define RCPWC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rcpwc_pkg.sv =====
// Package for the RC pulse-width capture block: payload structs, register
// indexes, widths and reset constants. No dependencies.
`timescale 1ns / 1ps

package rcpwc_pkg;

	localparam int PIN_W       = 5;
	localparam int TS_W        = 32;
	localparam int WIDTH_W     = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int REPORTED    = 4;
	localparam int MAX_PIN_REGS = 4;
	localparam int NUM_CH_DEF  = 4;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Configuration register indexes
	localparam cfg_idx_t REG_PIN_CH0   = cfg_idx_t'(0);
	localparam cfg_idx_t REG_MIN_WIDTH = cfg_idx_t'(4);
	localparam cfg_idx_t REG_MAX_WIDTH = cfg_idx_t'(5);

	// Reset values
	localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST = WIDTH_W'(900);
	localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST = WIDTH_W'(2100);
	localparam logic [WIDTH_W-1:0] WIDTH_RST     = WIDTH_W'(1500);
	localparam logic [WIDTH_W-1:0] WIDTH_RST_CH2 = WIDTH_W'(1000);

	// Edge event
	typedef struct packed {
		logic [PIN_W-1:0] pin;
		logic             edge_rise;
		logic             edge_fall;
		logic [TS_W-1:0]  timestamp;
	} evt_t;

	// Capture report
	typedef struct packed {
		logic               pin_matched;
		logic [WIDTH_W-1:0] width_ch0;
		logic [WIDTH_W-1:0] width_ch1;
		logic [WIDTH_W-1:0] width_ch2;
		logic [WIDTH_W-1:0] width_ch3;
		logic               valid_ch0;
		logic               valid_ch1;
		logic               valid_ch2;
		logic               valid_ch3;
		logic               all_valid;
	} res_t;

	// Per-channel update controls for one transfer
	typedef struct packed {
		logic hit;
		logic rise;
		logic fall;
	} chan_ctrl_t;

	// Width held by a channel after reset
	function automatic logic [WIDTH_W-1:0] reset_width(input int ch);
		return (ch == 2) ? WIDTH_RST_CH2 : WIDTH_RST;
	endfunction

endpackage

// ===== rtl/rcpwc_chan.sv =====
// One capture channel: rise timestamp, last width and range flag.
// Depends on rcpwc_pkg.
`timescale 1ns / 1ps

module rcpwc_chan #(
	parameter logic [rcpwc_pkg::WIDTH_W-1:0] RESET_WIDTH = rcpwc_pkg::WIDTH_RST
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rcpwc_pkg::chan_ctrl_t           ctrl,
	input  logic [rcpwc_pkg::TS_W-1:0]      timestamp,
	input  logic [rcpwc_pkg::WIDTH_W-1:0]   min_width,
	input  logic [rcpwc_pkg::WIDTH_W-1:0]   max_width,
	output logic [rcpwc_pkg::WIDTH_W-1:0]   width_nxt,
	output logic                            ok_nxt
);

	logic [rcpwc_pkg::TS_W-1:0]    rise_stamp_q;
	logic [rcpwc_pkg::WIDTH_W-1:0] width_q;
	logic                          ok_q;
	logic [rcpwc_pkg::TS_W-1:0]    rise_eff;
	logic [rcpwc_pkg::TS_W-1:0]    diff;
	logic                          in_range;
	logic                          take_fall;

	// Rise is applied before fall, so both flags give a zero width
	assign rise_eff  = ctrl.rise ? timestamp : rise_stamp_q;
	assign diff      = timestamp - rise_eff;
	assign in_range  = (diff >= {{(rcpwc_pkg::TS_W-rcpwc_pkg::WIDTH_W){1'b0}}, min_width}) &&
	                   (diff <= {{(rcpwc_pkg::TS_W-rcpwc_pkg::WIDTH_W){1'b0}}, max_width});
	assign take_fall = ctrl.hit && ctrl.fall;

	assign width_nxt = take_fall ? diff[rcpwc_pkg::WIDTH_W-1:0] : width_q;
	assign ok_nxt    = take_fall ? in_range : ok_q;

	// Channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_stamp_q <= '0;
			width_q      <= RESET_WIDTH;
			ok_q         <= 1'b0;
		end else if (ctrl.hit) begin
			if (ctrl.rise) begin
				rise_stamp_q <= timestamp;
			end
			width_q <= width_nxt;
			ok_q    <= ok_nxt;
		end
	end

endmodule

// ===== rtl/rc_pulse_width_capture.sv =====
// RC pulse-width capture, top level: input stage, pin match, channels, result register.
// Depends on rcpwc_pkg and rcpwc_chan.
`timescale 1ns / 1ps

// Takes one edge event per clock while the result side is free and returns one report
// per event, registered first in the input stage and then in the result register. The
// channel update (32-bit subtract and range compare) is combinational and lies between
// the input stage and the result register. An input stage and the result register
// give two items of buffering, so an event is taken while a report waits.
// Channels at or above NUM_CHANNELS report zero; channels 4 and up watch the
// pin equal to their own number. Write the configuration only while idle.
module rc_pulse_width_capture #(
	parameter int NUM_CHANNELS = rcpwc_pkg::NUM_CH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              evt_valid,
	output logic                              evt_ready,
	input  rcpwc_pkg::evt_t                   evt,
	output logic                              res_valid,
	input  logic                              res_ready,
	output rcpwc_pkg::res_t                   res,
	input  logic                              cfg_we,
	input  logic [rcpwc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rcpwc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int PIN_REGS = (NUM_CHANNELS < rcpwc_pkg::MAX_PIN_REGS) ?
	                          NUM_CHANNELS : rcpwc_pkg::MAX_PIN_REGS;

	logic [rcpwc_pkg::PIN_W-1:0]   cfg_pin_q [PIN_REGS];
	logic [rcpwc_pkg::WIDTH_W-1:0] min_width_q;
	logic [rcpwc_pkg::WIDTH_W-1:0] max_width_q;

	rcpwc_pkg::evt_t               evt_s1;
	logic                          valid_s1;
	logic                          adv;
	logic                          res_valid_q;
	rcpwc_pkg::res_t               res_q;
	rcpwc_pkg::res_t               res_nxt;

	logic [NUM_CHANNELS-1:0]       hit;
	logic [NUM_CHANNELS-1:0]       sel;
	logic [NUM_CHANNELS-1:0]       ok_nxt;
	logic [rcpwc_pkg::WIDTH_W-1:0] width_nxt [NUM_CHANNELS];
	logic [rcpwc_pkg::WIDTH_W-1:0] width_rep [rcpwc_pkg::REPORTED];
	logic [rcpwc_pkg::REPORTED-1:0] ok_rep;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIN_REGS; i++) begin
				cfg_pin_q[i] <= rcpwc_pkg::PIN_W'(i);
			end
			min_width_q <= rcpwc_pkg::MIN_WIDTH_RST;
			max_width_q <= rcpwc_pkg::MAX_WIDTH_RST;
		end else if (cfg_we) begin
			for (int i = 0; i < PIN_REGS; i++) begin
				if (cfg_index == rcpwc_pkg::REG_PIN_CH0 + rcpwc_pkg::cfg_idx_t'(i)) begin
					cfg_pin_q[i] <= cfg_data[rcpwc_pkg::PIN_W-1:0];
				end
			end
			if (cfg_index == rcpwc_pkg::REG_MIN_WIDTH) begin
				min_width_q <= cfg_data[rcpwc_pkg::WIDTH_W-1:0];
			end
			if (cfg_index == rcpwc_pkg::REG_MAX_WIDTH) begin
				max_width_q <= cfg_data[rcpwc_pkg::WIDTH_W-1:0];
			end
		end
	end

	// Handshake: stage 1 moves on whenever the result register is free or drains
	assign adv       = valid_s1 && (!res_valid_q || res_ready);
	assign evt_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt_valid && evt_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && evt_ready) begin
			evt_s1 <= evt;
		end
	end

	// Pin compare per channel, then channel state
	for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_ch
		rcpwc_pkg::chan_ctrl_t ctrl;

		if (c < PIN_REGS) begin : g_cfg_pin
			assign hit[c] = (evt_s1.pin == cfg_pin_q[c]);
		end else begin : g_fixed_pin
			assign hit[c] = (evt_s1.pin == rcpwc_pkg::PIN_W'(c));
		end

		assign ctrl.hit  = adv && sel[c];
		assign ctrl.rise = evt_s1.edge_rise;
		assign ctrl.fall = evt_s1.edge_fall;

		rcpwc_chan #(
			.RESET_WIDTH(rcpwc_pkg::reset_width(c))
		) u_chan (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.timestamp (evt_s1.timestamp),
			.min_width (min_width_q),
			.max_width (max_width_q),
			.width_nxt (width_nxt[c]),
			.ok_nxt    (ok_nxt[c])
		);
	end

	// Lowest-numbered matching channel wins
	always_comb begin
		logic found;
		found = 1'b0;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			sel[c] = hit[c] && !found;
			found  = found || hit[c];
		end
	end

	// Reported channels; missing ones read zero
	for (genvar k = 0; k < rcpwc_pkg::REPORTED; k++) begin : g_rep
		if (k < NUM_CHANNELS) begin : g_have
			assign width_rep[k] = width_nxt[k];
			assign ok_rep[k]    = ok_nxt[k];
		end else begin : g_none
			assign width_rep[k] = '0;
			assign ok_rep[k]    = 1'b0;
		end
	end

	always_comb begin
		res_nxt             = '0;
		res_nxt.pin_matched = |hit;
		res_nxt.width_ch0   = width_rep[0];
		res_nxt.width_ch1   = width_rep[1];
		res_nxt.width_ch2   = width_rep[2];
		res_nxt.width_ch3   = width_rep[3];
		res_nxt.valid_ch0   = ok_rep[0];
		res_nxt.valid_ch1   = ok_rep[1];
		res_nxt.valid_ch2   = ok_rep[2];
		res_nxt.valid_ch3   = ok_rep[3];
		res_nxt.all_valid   = &ok_nxt;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== rtl/rcpwc_checker.sv =====
// Port-level checker for the RC pulse-width capture block, bound to the top level.
// Depends on rcpwc_pkg and rc_pulse_width_capture_assert.svh.
`timescale 1ns / 1ps
`include "rc_pulse_width_capture_assert.svh"

module rcpwc_checker #(
	parameter int NUM_CHANNELS = rcpwc_pkg::NUM_CH_DEF
) (
	input logic            clk,
	input logic            arst_n,
	input logic            evt_valid,
	input logic            evt_ready,
	input logic            res_valid,
	input logic            res_ready,
	input rcpwc_pkg::res_t res
);

	localparam int NREP = (NUM_CHANNELS < rcpwc_pkg::REPORTED) ?
	                      NUM_CHANNELS : rcpwc_pkg::REPORTED;
	localparam logic [rcpwc_pkg::REPORTED-1:0] EXIST =
		rcpwc_pkg::REPORTED'((1 << NREP) - 1);

	logic [rcpwc_pkg::REPORTED-1:0] vld;
	logic                           evt_xfer;

	assign vld      = {res.valid_ch3, res.valid_ch2, res.valid_ch1, res.valid_ch0};
	assign evt_xfer = evt_valid && evt_ready;

	// all_valid needs every existing reported channel valid
	`RCPWC_ASSERT_IMP(a_all_valid, res_valid && res.all_valid, (vld & EXIST) == EXIST, "all_valid with an invalid channel")

	// Channels that do not exist never report valid
	`RCPWC_ASSERT_IMP(a_absent_zero, res_valid, (vld & ~EXIST) == '0, "absent channel reports valid")

	// An event taken into an empty block reaches the result side through the input stage and the result register
	`RCPWC_ASSERT_IMP(a_latency, evt_xfer && !res_valid, ##2 res_valid, "report missing after transfer")

	// A waiting report holds
	`RCPWC_ASSERT_IMP(a_res_hold, res_valid && !res_ready, ##1 (res_valid && $stable(res)), "stalled report changed")

endmodule

bind rc_pulse_width_capture rcpwc_checker #(
	.NUM_CHANNELS(NUM_CHANNELS)
) u_rcpwc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.evt_valid (evt_valid),
	.evt_ready (evt_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);
